// File: rtl/core/rdc_pkg.sv
// Shared definitions for the radix digit converter: field layout, cell control
// and the digit-to-character map. Depends on nothing; every core file imports it.
package rdc_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int VALUE_FIELD_W  = 64;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int RADIX_LSB      = VALUE_FIELD_W;
    localparam int UPPER_BIT      = RADIX_LSB + RADIX_W;
    localparam int IN_TDATA_W     = 72;
    localparam int OUT_TDATA_W    = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

    // Broadcast control for every cell of the digit row.
    typedef struct packed {
        logic               clear;
        logic               shift;
        logic [RADIX_W-1:0] base;
    } t_cell_ctrl;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] res;
        if (d < 4'd10) begin
            res = CHAR_ZERO + CHAR_W'(d);
        end else if (upper) begin
            res = CHAR_UPPER_A + CHAR_W'(d - 4'd10);
        end else begin
            res = CHAR_LOWER_A + CHAR_W'(d - 4'd10);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/rdc_cell.sv
// One digit cell of the conversion row: doubles its digit, adds the carry from
// its less significant neighbor and reduces by the base. Depends on rdc_pkg.
module rdc_cell
    import rdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_en,
    input  logic               i_carry,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_en,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic               r_en;
    logic               r_carry;
    logic [DIGIT_W:0]   w_sum;
    logic [DIGIT_W:0]   w_diff;
    logic               w_ge;

    assign w_sum  = {r_digit, i_carry};
    assign w_ge   = (w_sum >= i_ctrl.base);
    assign w_diff = w_sum - i_ctrl.base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_ctrl.clear || i_ctrl.shift) begin
            r_en <= 1'b0;
        end else begin
            r_en <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit;
        end else if (i_en) begin
            r_digit <= w_ge ? w_diff[DIGIT_W-1:0] : w_sum[DIGIT_W-1:0];
        end
        r_carry <= w_ge;
    end

    assign o_en    = r_en;
    assign o_carry = r_carry;
    assign o_digit = r_digit;

endmodule

// File: rtl/core/rdc_chain.sv
// Row of digit cells, least significant digit in cell zero, with a skewed
// carry hand-off between neighbors. Depends on rdc_pkg and rdc_cell.
module rdc_chain
    import rdc_pkg::*;
#(
    parameter int CELLS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_en,
    input  logic               i_bit,
    output logic               o_active,
    output logic [DIGIT_W-1:0] o_top_digit
);

    logic               w_en    [0:CELLS];
    // The carry out of the top cell is not used: a value of CELLS bits has at
    // most CELLS digits in any base from two up.
    logic               w_carry [0:CELLS];
    logic [DIGIT_W-1:0] w_digit [0:CELLS-1];
    logic [CELLS-1:0]   w_busy;

    assign w_en[0]    = i_en;
    assign w_carry[0] = i_bit;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        logic [DIGIT_W-1:0] w_from;
        if (i == 0) begin : g_first
            assign w_from = '0;
        end else begin : g_inner
            assign w_from = w_digit[i-1];
        end
        rdc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_en    (w_en[i]),
            .i_carry (w_carry[i]),
            .i_digit (w_from),
            .o_en    (w_en[i+1]),
            .o_carry (w_carry[i+1]),
            .o_digit (w_digit[i])
        );
        assign w_busy[i] = w_en[i+1];
    end

    assign o_active    = |w_busy;
    assign o_top_digit = w_digit[CELLS-1];

endmodule

// File: rtl/core/radix_digit_converter.sv
// Top level of the radix digit converter: input transaction capture, sequencing
// of the digit cell row and the output register. Depends on rdc_pkg and rdc_chain.
//
// Usage. The slave channel (i_s_*) takes one transaction per number: the value,
// a radix that is clamped into 2..16, and an upper-case flag. The master channel
// (o_m_*) returns that number's ASCII digits, most significant first, without
// leading zeros; zero gives a single '0'. o_m_tlast marks the final digit.
//
// Operation. A row of VALUE_BITS digit cells converts the value with the
// shift-and-double method: value bits enter cell zero most significant first,
// and each carry is registered on its way to the next cell. Once the row has
// settled, it shifts toward its top cell; leading zero digits are dropped
// there, and every other digit is one output transaction.
//
// Reset and stalls. Reset idles the sequencer and empties the output register.
// When the receiver holds i_m_tready low, leading zeros are still dropped, but
// the row stops shifting as soon as a shown digit waits behind the pending one
// in the output register. Once the final digit is in the output register, the
// next number can be accepted while that digit still waits.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // Fields from bit 0 up: value (64), radix (5), upper_case (1), two zero bits.
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // Fields from bit 0 up: digit_char (7), one zero bit.
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] FEED_END = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] ONE_LEFT = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                  r_state;
    logic [VALUE_BITS-1:0]   r_value;
    logic [RADIX_W-1:0]      r_base;
    logic                    r_upper;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_left;
    logic                    r_seen;
    logic                    r_ovalid;
    logic [CHAR_W-1:0]       r_char;
    logic                    r_last;

    logic                    w_accept;
    logic                    w_feed;
    logic                    w_show;
    logic                    w_skip;
    logic                    w_load;
    logic                    w_active;
    logic [DIGIT_W-1:0]      w_top;
    t_cell_ctrl              w_ctrl;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_feed     = (r_state == S_CONV) && (r_cnt != FEED_END);

    // A digit is shown once a nonzero digit has appeared, and the least
    // significant digit is always shown so that zero still gives one digit.
    assign w_show = r_seen || (w_top != '0) || (r_left == ONE_LEFT);
    assign w_skip = (r_state == S_EMIT) && !w_show;
    assign w_load = (r_state == S_EMIT) && w_show && (!r_ovalid || i_m_tready);

    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = w_skip || w_load;
    assign w_ctrl.base  = r_base;

    rdc_chain #(
        .CELLS (VALUE_BITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_en        (w_feed),
        .i_bit       (r_value[VALUE_BITS-1]),
        .o_active    (w_active),
        .o_top_digit (w_top)
    );

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                        r_seen  <= 1'b0;
                    end
                end
                S_CONV: begin
                    if (w_feed) begin
                        r_cnt <= r_cnt + ONE_LEFT;
                    end else if (!w_active) begin
                        // The last carry has left the top cell: digits are final.
                        r_state <= S_EMIT;
                        r_left  <= FEED_END;
                    end
                end
                S_EMIT: begin
                    if (w_skip || w_load) begin
                        r_left <= r_left - ONE_LEFT;
                    end
                    if (w_load) begin
                        r_seen <= 1'b1;
                        if (r_left == ONE_LEFT) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_s_tdata[VALUE_BITS-1:0];
            r_base  <= clamp_radix(i_s_tdata[RADIX_LSB +: RADIX_W]);
            r_upper <= i_s_tdata[UPPER_BIT];
        end else if (w_feed) begin
            r_value <= {r_value[VALUE_BITS-2:0], 1'b0};
        end
        if (w_load) begin
            r_char <= digit_char(w_top, r_upper);
            r_last <= (r_left == ONE_LEFT);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_char};
    assign o_m_tlast  = r_last;

endmodule
